[rtl/core/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the sorted list engine: command and status codes,
// cell actions and compare modes, control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_POP_FRONT = 3'd2,
        CMD_POP_BACK  = 3'd3,
        CMD_REMOVE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_HOLD      = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_APPEND    = 3'd2,
        ACT_SHIFT_ALL = 3'd3,
        ACT_REMOVE    = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        CMP_NONE = 2'd0,
        CMP_GT   = 2'd1,
        CMP_LE   = 2'd2,
        CMP_EQ   = 2'd3
    } cmp_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CMP   = 3'd1,
        S_GRP   = 3'd2,
        S_APPLY = 3'd3,
        S_SEL1  = 3'd4,
        S_SEL2  = 3'd5,
        S_DONE  = 3'd6
    } state_t;

    typedef struct packed {
        logic cmp_en;
        cmp_t cmp_mode;
        act_t act;
    } cell_ctl_t;

    // cells per group in the prefix and read-out trees
    localparam int SEL_GRP = 8;

endpackage

`default_nettype wire

[rtl/core/sorted_list_engine_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine_top
// Bounded ordered list built as a row of cells, with sorted insert, append,
// pop front, pop back and remove by value.
// ----------------------------------------------------------------------------
// A request passes in order through compare, in which every cell compares its
// entry against the request value; group, which reduces the hits per group of
// eight cells; apply, in which the row shifts and writes in place; the two
// registered stages of the read-out tree that picks the back entry; the result,
// held until it is taken; and idle, in which the next request is taken. The
// list holds CAPACITY entries of DATA_WIDTH bits; wider entries are fed from
// the 32-bit value zero-extended and reported truncated to 32 bits. The sort
// order register may be written only while no request is in flight.
`default_nettype none

module sorted_list_engine_top #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_command,
    input  logic [31:0]      s_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_popped_value,
    output logic [31:0]      m_front_value,
    output logic [31:0]      m_back_value,
    output logic [CNT_W-1:0] m_entry_count
);
    import sle_pkg::*;

    localparam int IN_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int NGRP = (CAPACITY + SEL_GRP - 1) / SEL_GRP;

    state_t                state_reg, state_next;
    logic                  desc_reg;
    cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cnt_old_reg;
    logic [DATA_WIDTH-1:0] front_old_reg;
    status_t               status_reg, status_next;
    logic [NGRP-1:0]       grp_any_reg;

    logic                  accept;
    cell_ctl_t             ctl;
    cmp_t                  cmp_sel;
    act_t                  act_sel;
    status_t               status_sel;
    logic [CNT_W-1:0]      count_sel;
    logic                  list_full, list_empty, found;

    logic [CAPACITY-1:0]                 hit_vec;
    logic [NGRP*SEL_GRP-1:0]             hit_pad;
    logic [NGRP-1:0]                     grp_any;
    logic [NGRP-1:0]                     grp_pre;
    logic [CAPACITY-1:0]                 prefix;
    logic [CAPACITY-1:0]                 occupied, at_end;
    logic [CAPACITY-1:0]                 sel_back, sel_last_old;
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_data;
    logic [DATA_WIDTH-1:0]               back_q, last_old_q;
    logic [DATA_WIDTH-1:0]               popped;

    assign accept = s_valid && s_ready;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            desc_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (cfg_wr_en) begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    // request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= cmd_t'(s_command);
            val_reg     <= DATA_WIDTH'(s_value[IN_W-1:0]);
            cnt_old_reg <= count_reg;
        end
        if (state_reg == S_CMP) begin
            front_old_reg <= cell_data[0];
        end
        if (state_reg == S_GRP) begin
            grp_any_reg <= grp_any;
        end
    end

    // decision for the update step
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign found      = |grp_any_reg;

    always_comb begin
        cmp_sel    = CMP_NONE;
        act_sel    = ACT_HOLD;
        status_sel = STAT_OK;
        count_sel  = count_reg;
        unique case (cmd_reg)
            CMD_INSERT: begin
                cmp_sel = desc_reg ? CMP_LE : CMP_GT;
                if (list_full) begin
                    status_sel = STAT_FULL;
                end else begin
                    act_sel   = ACT_INSERT;
                    count_sel = count_reg + 1'b1;
                end
            end
            CMD_APPEND: begin
                if (list_full) begin
                    status_sel = STAT_FULL;
                end else begin
                    act_sel   = ACT_APPEND;
                    count_sel = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (list_empty) begin
                    status_sel = STAT_EMPTY;
                end else begin
                    act_sel   = ACT_SHIFT_ALL;
                    count_sel = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (list_empty) begin
                    status_sel = STAT_EMPTY;
                end else begin
                    count_sel = count_reg - 1'b1;
                end
            end
            CMD_REMOVE: begin
                cmp_sel = CMP_EQ;
                if (list_empty) begin
                    status_sel = STAT_EMPTY;
                end else if (!found) begin
                    status_sel = STAT_NOTFOUND;
                end else begin
                    act_sel   = ACT_REMOVE;
                    count_sel = count_reg - 1'b1;
                end
            end
            default: begin
                status_sel = STAT_OK;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        ctl.cmp_en   = 1'b0;
        ctl.cmp_mode = cmp_sel;
        ctl.act      = ACT_HOLD;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctl.cmp_en = 1'b1;
                state_next = S_GRP;
            end
            S_GRP: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                ctl.act     = act_sel;
                count_next  = count_sel;
                status_next = status_sel;
                state_next  = S_SEL1;
            end
            S_SEL1: begin
                state_next = S_SEL2;
            end
            S_SEL2: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hit prefix: groups of cells, then a short chain inside each group
    assign hit_pad = (NGRP*SEL_GRP)'(hit_vec);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |hit_pad[g*SEL_GRP +: SEL_GRP];
        end
    end

    always_comb begin
        grp_pre[0] = 1'b0;
        for (int g = 1; g < NGRP; g++) begin
            grp_pre[g] = grp_pre[g-1] | grp_any_reg[g-1];
        end
    end

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i % SEL_GRP == 0) begin : g_head
            assign prefix[i] = grp_pre[i / SEL_GRP];
        end else begin : g_body
            assign prefix[i] = prefix[i-1] | hit_vec[i-1];
        end

        assign occupied[i]     = (CNT_W'(i) < count_reg);
        assign at_end[i]       = (CNT_W'(i) == count_reg);
        assign sel_back[i]     = (CNT_W'(i + 1) == count_reg);
        assign sel_last_old[i] = (CNT_W'(i + 1) == cnt_old_reg);

        sle_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .operand    (val_reg),
            .occupied   (occupied[i]),
            .at_end     (at_end[i]),
            .prefix_hit (prefix[i]),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .hit        (hit_vec[i]),
            .data       (cell_data[i])
        );
    end

    // back entry after the request and last entry before it
    sle_sel_tree #(
        .N (CAPACITY),
        .W (DATA_WIDTH)
    ) u_back_tree (
        .aclk (aclk),
        .sel  (sel_back),
        .data (cell_data),
        .q    (back_q)
    );

    sle_sel_tree #(
        .N (CAPACITY),
        .W (DATA_WIDTH)
    ) u_last_tree (
        .aclk (aclk),
        .sel  (sel_last_old),
        .data (cell_data),
        .q    (last_old_q)
    );

    // result
    always_comb begin
        popped = '0;
        if (status_reg == STAT_OK) begin
            unique case (cmd_reg)
                CMD_POP_FRONT: popped = front_old_reg;
                CMD_POP_BACK:  popped = last_old_q;
                CMD_REMOVE:    popped = val_reg;
                default:       popped = '0;
            endcase
        end
    end

    assign m_status       = status_reg;
    assign m_popped_value = 32'(popped);
    assign m_front_value  = list_empty ? 32'd0 : 32'(cell_data[0]);
    assign m_back_value   = list_empty ? 32'd0 : 32'(back_q);
    assign m_entry_count  = count_reg;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && (ctl.act == ACT_INSERT || ctl.act == ACT_APPEND))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_EMPTY) |-> m_entry_count == '0)
        else $error("empty status with stored entries");
`endif

endmodule

`default_nettype wire

[rtl/core/sle_cell.sv]
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, compares it against the operand and moves
// data to or from its neighbours when the row is updated.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  sle_pkg::cell_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0] operand,
    input  logic                  occupied,
    input  logic                  at_end,
    input  logic                  prefix_hit,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic                  hit,
    output logic [DATA_WIDTH-1:0] data
);
    import sle_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  hit_reg, hit_next;

    always_comb begin
        hit_next = hit_reg;
        if (ctl.cmp_en) begin
            unique case (ctl.cmp_mode)
                CMP_NONE: hit_next = 1'b0;
                CMP_GT:   hit_next = occupied && (data_reg > operand);
                CMP_LE:   hit_next = occupied && (data_reg <= operand);
                CMP_EQ:   hit_next = occupied && (data_reg == operand);
            endcase
        end
    end

    always_comb begin
        data_next = data_reg;
        unique case (ctl.act)
            ACT_HOLD: begin
                data_next = data_reg;
            end
            ACT_INSERT: begin
                if (prefix_hit) begin
                    data_next = left_data;
                end else if (hit_reg || at_end) begin
                    data_next = operand;
                end
            end
            ACT_APPEND: begin
                if (at_end) begin
                    data_next = operand;
                end
            end
            ACT_SHIFT_ALL: begin
                data_next = right_data;
            end
            ACT_REMOVE: begin
                if (prefix_hit || hit_reg) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign hit  = hit_reg;
    assign data = data_reg;

endmodule

`default_nettype wire

[rtl/core/sle_sel_tree.sv]
// ----------------------------------------------------------------------------
// sle_sel_tree
// Two-stage registered and-or tree that reads out the one cell picked by a
// one-hot select.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_sel_tree #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic [N-1:0]        sel,
    input  logic [N-1:0][W-1:0] data,
    output logic [W-1:0]        q
);
    import sle_pkg::*;

    localparam int NGRP = (N + SEL_GRP - 1) / SEL_GRP;

    logic [NGRP-1:0][W-1:0] part_reg, part_next;
    logic [W-1:0]           q_reg, q_next;

    always_comb begin
        part_next = '0;
        for (int j = 0; j < N; j++) begin
            part_next[j / SEL_GRP] = part_next[j / SEL_GRP] | (data[j] & {W{sel[j]}});
        end
    end

    always_comb begin
        q_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            q_next = q_next | part_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        q_reg    <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire
